[rtl/kcd_pkg.sv]
// Package for the keyword command decoder: payload types, codes, keyword and color tables.
package kcd_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_command;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  port_bits;
		logic [10:0] servo_compare;
		logic [7:0]  red_duty;
		logic [7:0]  green_duty;
		logic [7:0]  blue_duty;
	} rsp_t;

	typedef struct packed {
		logic [2:0] led_lowest;
		logic [2:0] led_highest;
		logic [7:0] angle_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		KW_LEDON  = 2'd0,
		KW_LEDOFF = 2'd1,
		KW_SERVO  = 2'd2,
		KW_COLOR  = 2'd3
	} kw_t;

	// Decoded command handed from the parser to the executor.
	typedef struct packed {
		logic       known;
		kw_t        kw;
		logic [7:0] number;
	} cmd_info_t;

	typedef enum logic [1:0] {
		REG_LED_LOWEST  = 2'd0,
		REG_LED_HIGHEST = 2'd1,
		REG_ANGLE_LIMIT = 2'd2
	} reg_index_t;

	localparam int          KwCount     = 4;
	localparam logic [4:0]  PosMax      = 5'd31;

	localparam logic [3:0]  ST_LEDON      = 4'd0;
	localparam logic [3:0]  ST_LEDOFF     = 4'd1;
	localparam logic [3:0]  ST_SERVO      = 4'd2;
	localparam logic [3:0]  ST_COLOR      = 4'd3;
	localparam logic [3:0]  ST_BAD_OFFSET = 4'd4;
	localparam logic [3:0]  ST_UNKNOWN    = 4'd8;

	// floor(n*999/180) = (n * ServoRecip) >> ServoShift for every 8-bit n
	localparam logic [18:0] ServoRecip  = 19'd363725;
	localparam int          ServoShift  = 16;
	localparam logic [11:0] ServoBase   = 12'd999;
	localparam logic [11:0] ServoMax    = 12'd1998;

	localparam logic [2:0]  LedLowestRst  = 3'd4;
	localparam logic [2:0]  LedHighestRst = 3'd7;
	localparam logic [7:0]  AngleLimitRst = 8'd180;

	localparam logic [7:0]  CharZero = 8'h30;
	localparam logic [7:0]  CharNine = 8'h39;

	function automatic logic [4:0] kw_len(input logic [1:0] k);
		case (k)
			KW_LEDOFF: kw_len = 5'd6;
			default:   kw_len = 5'd5;
		endcase
	endfunction

	// Character of keyword k at position pos; only meaningful below kw_len(k).
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [47:0] txt;
		case (k)
			KW_LEDON:  txt = {"ledon", 8'h00};
			KW_LEDOFF: txt = "ledoff";
			KW_SERVO:  txt = {"servo", 8'h00};
			default:   txt = {"color", 8'h00};
		endcase
		case (pos)
			3'd0:    kw_char = txt[47:40];
			3'd1:    kw_char = txt[39:32];
			3'd2:    kw_char = txt[31:24];
			3'd3:    kw_char = txt[23:16];
			3'd4:    kw_char = txt[15:8];
			3'd5:    kw_char = txt[7:0];
			default: kw_char = 8'h00;
		endcase
	endfunction

	// Duty triple {red, green, blue} for color index 0..2.
	function automatic logic [23:0] color_duty(input logic [1:0] idx);
		case (idx)
			2'd0:    color_duty = {8'd254, 8'd254, 8'd1};
			2'd1:    color_duty = {8'd1, 8'd254, 8'd254};
			default: color_duty = {8'd254, 8'd254, 8'd254};
		endcase
	endfunction

endpackage

[rtl/keyword_command_decoder_unit.sv]
// Top level of the keyword command decoder: input stage, parser, executor, config registers.
//
// Channel  | Direction | Handshake             | Beat
// ---------+-----------+-----------------------+------------------------------------
// cmd      | in        | cmd_valid / cmd_stall | one received byte + end flag
// rsp      | out       | rsp_valid / rsp_stall | status and register values per command
// cfg      | in        | cfg_valid / cfg_ready | register index and write data
//
// One byte per cycle while cmd_stall is low: a beat lands in the input register, where
// the parser and executor act on it, and an end beat then fills the result register.
// A command's result passes the input register and then the result register.
// Only an end beat waits on the result register; other bytes always advance, so
// cmd_stall rises only while an end beat sits in front of a full, stalled result.
// Reset clears the parse state, the LED port, servo and color registers and the
// config registers to their defaults; cfg is always ready.
module keyword_command_decoder_unit import kcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_t       cmd,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      adv;
	logic      accept;
	logic      free;
	cfg_t      cfg_q;
	cmd_info_t info;

	// Advance the held beat unless it ends a command and the result slot is busy.
	assign adv       = valid_s1 && (!cmd_s1.end_of_command || free);
	assign cmd_stall = valid_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload until a new beat is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// Config writes; drop any index past the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_lowest  <= LedLowestRst;
			cfg_q.led_highest <= LedHighestRst;
			cfg_q.angle_limit <= AngleLimitRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LED_LOWEST:  cfg_q.led_lowest  <= cfg_data[2:0];
				REG_LED_HIGHEST: cfg_q.led_highest <= cfg_data[2:0];
				REG_ANGLE_LIMIT: cfg_q.angle_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	kcd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd_s1 (cmd_s1),
		.info   (info)
	);

	kcd_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && cmd_s1.end_of_command),
		.info      (info),
		.cfg       (cfg_q),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.free      (free)
	);

endmodule

[rtl/kcd_parser.sv]
// Keyword and number parser: holds the per-command parse state.
module kcd_parser import kcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  cmd_t      cmd_s1,
	output cmd_info_t info
);

	logic [4:0] pos_q;
	logic [3:0] alive_q;
	logic       in_digits_q;
	logic       bad_q;
	logic [7:0] num_q;

	logic [4:0] pos_n;
	logic [3:0] alive_n;
	logic       in_digits_n;
	logic       bad_n;
	logic [7:0] num_n;
	logic [3:0] match;
	logic [3:0] done_now;
	logic [3:0] done_next;
	logic [3:0] mask;
	logic       dig;
	logic [7:0] digit;

	always_comb begin
		dig   = (cmd_s1.rx_byte >= CharZero) && (cmd_s1.rx_byte <= CharNine);
		digit = cmd_s1.rx_byte - CharZero;
		for (int k = 0; k < KwCount; k++) begin
			match[k]    = alive_q[k] && (pos_q < kw_len(2'(k))) &&
			              (kw_char(2'(k), pos_q[2:0]) == cmd_s1.rx_byte);
			done_now[k] = alive_q[k] && (kw_len(2'(k)) == pos_q);
		end

		pos_n       = pos_q;
		alive_n     = alive_q;
		in_digits_n = in_digits_q;
		bad_n       = bad_q;
		num_n       = num_q;
		if (in_digits_q) begin
			if (dig) begin
				num_n = {num_q[4:0], 3'b000} + {num_q[6:0], 1'b0} + digit;
			end else begin
				bad_n = 1'b1;
			end
		end else if (dig) begin
			if (done_now == 4'd0) begin
				bad_n = 1'b1;
			end else begin
				alive_n     = done_now;
				in_digits_n = 1'b1;
				num_n       = digit;
			end
		end else begin
			alive_n = match;
			if (pos_q != PosMax) begin
				pos_n = pos_q + 5'd1;
			end
		end

		for (int k = 0; k < KwCount; k++) begin
			done_next[k] = alive_n[k] && (kw_len(2'(k)) == pos_n);
		end
		mask = in_digits_n ? alive_n : done_next;

		info.known  = !bad_n && (mask != 4'd0);
		info.number = num_n;
		if (mask[0]) begin
			info.kw = KW_LEDON;
		end else if (mask[1]) begin
			info.kw = KW_LEDOFF;
		end else if (mask[2]) begin
			info.kw = KW_SERVO;
		end else begin
			info.kw = KW_COLOR;
		end
	end

	// Clear after an end beat, else take the updated state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			alive_q     <= '1;
			in_digits_q <= 1'b0;
			bad_q       <= 1'b0;
			num_q       <= '0;
		end else if (adv) begin
			if (cmd_s1.end_of_command) begin
				pos_q       <= '0;
				alive_q     <= '1;
				in_digits_q <= 1'b0;
				bad_q       <= 1'b0;
				num_q       <= '0;
			end else begin
				pos_q       <= pos_n;
				alive_q     <= alive_n;
				in_digits_q <= in_digits_n;
				bad_q       <= bad_n;
				num_q       <= num_n;
			end
		end
	end

endmodule

[rtl/kcd_exec.sv]
// Command executor: LED port, servo and color registers plus the result register.
module kcd_exec import kcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  cmd_info_t info,
	input  cfg_t      cfg,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_t      rsp,
	output logic      free
);

	logic [7:0]  port_q;
	logic [10:0] servo_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [7:0]  port_n;
	logic [10:0] servo_n;
	logic [23:0] color_n;
	logic [3:0]  status;
	logic [26:0] prod;
	logic [11:0] scaled;
	logic        led_ok;
	logic [7:0]  bit_mask;

	always_comb begin
		prod     = {11'd0, info.number} * {8'd0, ServoRecip};
		scaled   = {1'b0, prod[ServoShift +: 11]} + ServoBase;
		led_ok   = (info.number >= {5'd0, cfg.led_lowest}) &&
		           (info.number <= {5'd0, cfg.led_highest});
		bit_mask = 8'd1 << info.number[2:0];

		port_n  = port_q;
		servo_n = servo_q;
		color_n = {red_q, green_q, blue_q};
		status  = ST_UNKNOWN;
		if (info.known) begin
			status = ST_BAD_OFFSET + {2'b00, info.kw};
			case (info.kw)
				KW_LEDON: begin
					if (led_ok) begin
						port_n = port_q | bit_mask;
						status = ST_LEDON;
					end
				end
				KW_LEDOFF: begin
					if (led_ok) begin
						port_n = port_q & ~bit_mask;
						status = ST_LEDOFF;
					end
				end
				KW_SERVO: begin
					if (info.number <= cfg.angle_limit) begin
						servo_n = (scaled > ServoMax) ? ServoMax[10:0] : scaled[10:0];
						status  = ST_SERVO;
					end
				end
				default: begin
					if (info.number <= 8'd2) begin
						color_n = color_duty(info.number[1:0]);
						status  = ST_COLOR;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q  <= '0;
			servo_q <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (load) begin
			port_q  <= port_n;
			servo_q <= servo_n;
			red_q   <= color_n[23:16];
			green_q <= color_n[15:8];
			blue_q  <= color_n[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status        <= status;
			rsp_q.port_bits     <= port_n;
			rsp_q.servo_compare <= servo_n;
			rsp_q.red_duty      <= color_n[23:16];
			rsp_q.green_duty    <= color_n[15:8];
			rsp_q.blue_duty     <= color_n[7:0];
		end
	end

	assign free      = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
